/* rtl/jdd_pkg.sv */
// Shared types, codes and constants of the joystick direction detector.
package jdd_pkg;

	// Raw converter sample width.
	localparam int SAMPLE_BITS = 12;
	localparam int EVENT_BITS  = 3;
	localparam int HELD_BITS   = 2;
	localparam int PHASE_BITS  = 3;
	localparam int CFG_IDX_BITS = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_NEG_ENTER   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_NEG_CONFIRM = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_POS_ENTER   = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_POS_CONFIRM = 2'd3;

	// Threshold reset values in raw counts.
	localparam logic [SAMPLE_BITS-1:0] NEG_ENTER_RST   = SAMPLE_BITS'(1229);
	localparam logic [SAMPLE_BITS-1:0] NEG_CONFIRM_RST = SAMPLE_BITS'(1024);
	localparam logic [SAMPLE_BITS-1:0] POS_ENTER_RST   = SAMPLE_BITS'(2866);
	localparam logic [SAMPLE_BITS-1:0] POS_CONFIRM_RST = SAMPLE_BITS'(3071);

	// Axis qualifier phases.
	localparam logic [PHASE_BITS-1:0] PH_IDLE     = 3'd0;
	localparam logic [PHASE_BITS-1:0] PH_NEG_CONF = 3'd1;
	localparam logic [PHASE_BITS-1:0] PH_NEG_HELD = 3'd2;
	localparam logic [PHASE_BITS-1:0] PH_POS_CONF = 3'd3;
	localparam logic [PHASE_BITS-1:0] PH_POS_HELD = 3'd4;

	// Event codes.
	localparam logic [EVENT_BITS-1:0] EV_NONE      = 3'd0;
	localparam logic [EVENT_BITS-1:0] EV_NEG_PRESS = 3'd1;
	localparam logic [EVENT_BITS-1:0] EV_NEG_REL   = 3'd2;
	localparam logic [EVENT_BITS-1:0] EV_POS_PRESS = 3'd3;
	localparam logic [EVENT_BITS-1:0] EV_POS_REL   = 3'd4;

	// Held direction codes.
	localparam logic [HELD_BITS-1:0] HELD_NONE = 2'd0;
	localparam logic [HELD_BITS-1:0] HELD_NEG  = 2'd1;
	localparam logic [HELD_BITS-1:0] HELD_POS  = 2'd2;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample_x;
		logic [SAMPLE_BITS-1:0] sample_y;
	} jdd_in_t;

	typedef struct packed {
		logic [EVENT_BITS-1:0] event_x;
		logic [EVENT_BITS-1:0] event_y;
		logic [HELD_BITS-1:0]  held_x;
		logic [HELD_BITS-1:0]  held_y;
	} jdd_out_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] neg_enter;
		logic [SAMPLE_BITS-1:0] neg_confirm;
		logic [SAMPLE_BITS-1:0] pos_enter;
		logic [SAMPLE_BITS-1:0] pos_confirm;
	} jdd_thresh_t;

endpackage

/* rtl/jdd_cfg_regs.sv */
// Threshold register file written through the configuration port.
module jdd_cfg_regs import jdd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [SAMPLE_BITS-1:0]  cfg_data,
	output jdd_thresh_t             thresh
);

	jdd_thresh_t thresh_q;

	// Decode the register index and update the addressed threshold.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q.neg_enter   <= NEG_ENTER_RST;
			thresh_q.neg_confirm <= NEG_CONFIRM_RST;
			thresh_q.pos_enter   <= POS_ENTER_RST;
			thresh_q.pos_confirm <= POS_CONFIRM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NEG_ENTER:   thresh_q.neg_enter   <= cfg_data;
				REG_NEG_CONFIRM: thresh_q.neg_confirm <= cfg_data;
				REG_POS_ENTER:   thresh_q.pos_enter   <= cfg_data;
				REG_POS_CONFIRM: thresh_q.pos_confirm <= cfg_data;
				default: ;
			endcase
		end
	end

	assign thresh = thresh_q;

endmodule

/* rtl/jdd_axis.sv */
// Five-phase hysteresis qualifier for one joystick axis.
module jdd_axis import jdd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  jdd_thresh_t            thresh,
	output logic [EVENT_BITS-1:0]  event_code,
	output logic [HELD_BITS-1:0]   held
);

	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] phase_d;

	// Next phase and event for the current sample.
	always_comb begin
		phase_d    = phase_q;
		event_code = EV_NONE;
		unique case (phase_q)
			PH_NEG_CONF: begin
				if (sample < thresh.neg_confirm) begin
					phase_d    = PH_NEG_HELD;
					event_code = EV_NEG_PRESS;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_NEG_HELD: begin
				if (sample >= thresh.neg_enter) begin
					phase_d    = PH_IDLE;
					event_code = EV_NEG_REL;
				end
			end
			PH_POS_CONF: begin
				if (sample > thresh.pos_confirm) begin
					phase_d    = PH_POS_HELD;
					event_code = EV_POS_PRESS;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_POS_HELD: begin
				if (sample <= thresh.pos_enter) begin
					phase_d    = PH_IDLE;
					event_code = EV_POS_REL;
				end
			end
			// Idle; unused codes behave the same way.
			default: begin
				if (sample < thresh.neg_enter) begin
					phase_d = PH_NEG_CONF;
				end else if (sample > thresh.pos_enter) begin
					phase_d = PH_POS_CONF;
				end else begin
					phase_d = PH_IDLE;
				end
			end
		endcase
	end

	// Held direction after this sample.
	always_comb begin
		case (phase_d)
			PH_NEG_HELD: held = HELD_NEG;
			PH_POS_HELD: held = HELD_POS;
			default:     held = HELD_NONE;
		endcase
	end

	// The phase moves only when the sample is handed to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (advance) begin
			phase_q <= phase_d;
		end
	end

endmodule

/* rtl/joystick_direction_detector_core.sv */
// Top level: input register, two axis qualifiers, result register.
// An accepted beat passes the input register, then the result register, to out_valid.
// Throughput: one pair per cycle unless stalled; the only loop is each axis phase register.
// out_stall reaches in_stall within the same cycle through the result register's load enable.
// Reset (arst_n low): both axes return to idle, the pipeline empties and the
// thresholds take their default raw counts.
module joystick_direction_detector_core import jdd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  jdd_in_t                 in_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output jdd_out_t                out_data,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [SAMPLE_BITS-1:0]  cfg_data
);

	jdd_thresh_t thresh;
	logic        valid_s1;
	jdd_in_t     data_s1;
	logic        valid_s2;
	jdd_out_t    data_s2;
	jdd_out_t    result;
	logic        advance;
	logic        in_take;

	jdd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.thresh    (thresh)
	);

	// Handshake: the stage-one beat moves on when the result register is free.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= in_data;
		end
	end

	jdd_axis u_axis_x (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.sample     (data_s1.sample_x),
		.thresh     (thresh),
		.event_code (result.event_x),
		.held       (result.held_x)
	);

	jdd_axis u_axis_y (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.sample     (data_s1.sample_y),
		.thresh     (thresh),
		.event_code (result.event_y),
		.held       (result.held_y)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

/* rtl/jdd_checker.sv */
// Port-level checks for the joystick direction detector, bound to the top level.
module jdd_checker import jdd_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_stall,
	input logic     out_valid,
	input logic     out_stall,
	input jdd_out_t out_data
);

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// A beat taken into an empty pipeline end shows a result once it has passed the input and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |-> ##2 out_valid)
		else $error("no result beat two cycles after input");

	// A press on the X axis leaves that axis with a direction held.
	a_press_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.event_x == EV_NEG_PRESS || out_data.event_x == EV_POS_PRESS)
		|-> out_data.held_x != HELD_NONE)
		else $error("X press without held direction");

	// A release leaves that axis with nothing held; the other axis is judged on its own.
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		((out_data.event_x != EV_NEG_REL && out_data.event_x != EV_POS_REL) ||
		out_data.held_x == HELD_NONE) &&
		((out_data.event_y != EV_NEG_REL && out_data.event_y != EV_POS_REL) ||
		out_data.held_y == HELD_NONE))
		else $error("release while a direction is still held");

endmodule

bind joystick_direction_detector_core jdd_checker u_jdd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

/* tb/joystick_direction_detector_core_tb.sv */
// Self-checking testbench for the joystick direction detector core: directed and random sample pairs.
module joystick_direction_detector_core_tb;
	import jdd_pkg::*;

	localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BLOCKS = 6;
	localparam int BLOCK_PAIRS   = 308;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	jdd_in_t in_data;
	logic out_valid;
	logic out_stall;
	jdd_out_t out_data;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [SAMPLE_BITS-1:0] cfg_data;

	// Predictor state: thresholds as last written and the phase of each axis.
	jdd_thresh_t thr;
	logic [PHASE_BITS-1:0] phase_x;
	logic [PHASE_BITS-1:0] phase_y;
	jdd_out_t pending_results[$];

	int gap_pct;
	int stall_pct;
	int error_count;
	int cycle_count;
	int pairs_sent;
	int results_checked;
	int press_count;
	int release_count;
	int settings_used;

	joystick_direction_detector_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Advance one axis qualifier by one sample and return the event it raises.
	function automatic logic [EVENT_BITS-1:0] advance_axis(inout logic [PHASE_BITS-1:0] ph,
			input logic [SAMPLE_BITS-1:0] s);
		logic [EVENT_BITS-1:0] ev;
		ev = EV_NONE;
		case (ph)
			PH_NEG_CONF: begin
				if (s < thr.neg_confirm) begin
					ph = PH_NEG_HELD;
					ev = EV_NEG_PRESS;
				end else begin
					ph = PH_IDLE;
				end
			end
			PH_NEG_HELD: begin
				if (s >= thr.neg_enter) begin
					ph = PH_IDLE;
					ev = EV_NEG_REL;
				end
			end
			PH_POS_CONF: begin
				if (s > thr.pos_confirm) begin
					ph = PH_POS_HELD;
					ev = EV_POS_PRESS;
				end else begin
					ph = PH_IDLE;
				end
			end
			PH_POS_HELD: begin
				if (s <= thr.pos_enter) begin
					ph = PH_IDLE;
					ev = EV_POS_REL;
				end
			end
			default: begin
				if (s < thr.neg_enter)
					ph = PH_NEG_CONF;
				else if (s > thr.pos_enter)
					ph = PH_POS_CONF;
				else
					ph = PH_IDLE;
			end
		endcase
		if (ev == EV_NEG_PRESS || ev == EV_POS_PRESS)
			press_count++;
		else if (ev != EV_NONE)
			release_count++;
		return ev;
	endfunction

	function automatic logic [HELD_BITS-1:0] held_of(input logic [PHASE_BITS-1:0] ph);
		if (ph == PH_NEG_HELD)
			return HELD_NEG;
		if (ph == PH_POS_HELD)
			return HELD_POS;
		return HELD_NONE;
	endfunction

	// Expected result for one accepted sample pair; updates both axis phases.
	function automatic jdd_out_t predict_pair(input jdd_in_t pair);
		jdd_out_t r;
		r.event_x = advance_axis(phase_x, pair.sample_x);
		r.event_y = advance_axis(phase_y, pair.sample_y);
		r.held_x  = held_of(phase_x);
		r.held_y  = held_of(phase_y);
		return r;
	endfunction

	// Uniform draw in [lo, hi]; an empty range falls back to the full scale.
	function automatic logic [SAMPLE_BITS-1:0] draw(input int lo, input int hi);
		if (lo < 0)
			lo = 0;
		if (hi > SAMPLE_MAX)
			hi = SAMPLE_MAX;
		if (lo > hi)
			return SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
		return SAMPLE_BITS'($urandom_range(hi, lo));
	endfunction

	// Pick a sample that tends to move the axis along a full press and release.
	function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [PHASE_BITS-1:0] ph);
		int ne;
		int nc;
		int pe;
		int pc;
		int roll;
		int edge_val;
		ne = thr.neg_enter;
		nc = thr.neg_confirm;
		pe = thr.pos_enter;
		pc = thr.pos_confirm;
		roll = $urandom_range(99);
		// Threshold neighborhoods and full-scale noise, whatever the phase.
		if (roll >= 95)
			return SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
		if (roll >= 88) begin
			case ($urandom_range(3))
				0: edge_val = ne;
				1: edge_val = nc;
				2: edge_val = pe;
				default: edge_val = pc;
			endcase
			return draw(edge_val - 1, edge_val + 1);
		end
		case (ph)
			PH_NEG_CONF, PH_NEG_HELD: begin
				if (roll < 60)
					return draw(0, nc - 1);
				if (roll < 72)
					return draw(nc, ne - 1);
				return draw(ne, pe);
			end
			PH_POS_CONF, PH_POS_HELD: begin
				if (roll < 60)
					return draw(pc + 1, SAMPLE_MAX);
				if (roll < 72)
					return draw(pe + 1, pc);
				return draw(ne, pe);
			end
			default: begin
				if (roll < 30)
					return draw(0, nc - 1);
				if (roll < 60)
					return draw(pc + 1, SAMPLE_MAX);
				if (roll < 68)
					return draw(nc, ne - 1);
				if (roll < 76)
					return draw(pe + 1, pc);
				return draw(ne, pe);
			end
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		error_count++;
	endtask

	// Send one sample pair; the expectation is queued at the edge that accepts the beat.
	task automatic send_pair(input logic [SAMPLE_BITS-1:0] sx, input logic [SAMPLE_BITS-1:0] sy);
		jdd_in_t pair;
		pair.sample_x = sx;
		pair.sample_y = sy;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= pair;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(predict_pair(pair));
		pairs_sent++;
	endtask

	// Drop valid and wait until every expected result has come out.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all four thresholds while the block is idle.
	task automatic program_thresholds(input logic [SAMPLE_BITS-1:0] ne,
			input logic [SAMPLE_BITS-1:0] nc, input logic [SAMPLE_BITS-1:0] pe,
			input logic [SAMPLE_BITS-1:0] pc);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_NEG_ENTER;
		cfg_data  <= ne;
		@(posedge clk);
		cfg_index <= REG_NEG_CONFIRM;
		cfg_data  <= nc;
		@(posedge clk);
		cfg_index <= REG_POS_ENTER;
		cfg_data  <= pe;
		@(posedge clk);
		cfg_index <= REG_POS_CONFIRM;
		cfg_data  <= pc;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr.neg_enter   = ne;
		thr.neg_confirm = nc;
		thr.pos_enter   = pe;
		thr.pos_confirm = pc;
		settings_used++;
	endtask

	// Press, hold and release on both axes at the reset thresholds, with exact boundaries.
	task automatic test_default_gestures();
		send_pair(12'd2048, 12'd2048);
		send_pair(12'd0, 12'd4095);
		send_pair(12'd0, 12'd4095);
		send_pair(12'd1228, 12'd2867);
		send_pair(12'd1229, 12'd2866);
		send_pair(12'd1228, 12'd2867);
		send_pair(12'd1024, 12'd3071);
		send_pair(12'd1228, 12'd2867);
		send_pair(12'd1023, 12'd3072);
		send_pair(12'd4095, 12'd0);
		send_pair(12'd4095, 12'd0);
		send_pair(12'd4095, 12'd0);
		send_pair(12'd2048, 12'd2048);
	endtask

	// Thresholds at the ends of the scale and in crossed order.
	task automatic test_threshold_extremes();
		// Nothing can ever enter a confirm phase.
		program_thresholds(12'd0, 12'd0, 12'd4095, 12'd4095);
		send_pair(12'd0, 12'd4095);
		send_pair(12'd0, 12'd4095);
		// Almost every sample counts as negative, and full scale as positive.
		program_thresholds(12'd4095, 12'd4095, 12'd0, 12'd0);
		send_pair(12'd0, 12'd0);
		send_pair(12'd0, 12'd0);
		send_pair(12'd4095, 12'd4095);
		send_pair(12'd4095, 12'd4095);
		send_pair(12'd4095, 12'd4095);
		// Crossed windows: the negative test wins in idle.
		program_thresholds(12'd3000, 12'd2000, 12'd1000, 12'd3500);
		send_pair(12'd2500, 12'd3600);
		send_pair(12'd1500, 12'd3600);
		send_pair(12'd3000, 12'd1000);
	endtask

	// Random gestures over several threshold settings and idling mixes.
	task automatic test_random_gestures();
		int unsigned nc;
		int unsigned ne;
		int unsigned pe;
		int unsigned pc;
		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			case (b)
				0: begin
					nc = NEG_CONFIRM_RST;
					ne = NEG_ENTER_RST;
					pe = POS_ENTER_RST;
					pc = POS_CONFIRM_RST;
				end
				2: begin
					nc = $urandom_range(SAMPLE_MAX);
					ne = $urandom_range(SAMPLE_MAX);
					pe = $urandom_range(SAMPLE_MAX);
					pc = $urandom_range(SAMPLE_MAX);
				end
				4: begin
					nc = 1;
					ne = 1;
					pe = SAMPLE_MAX - 1;
					pc = SAMPLE_MAX - 1;
				end
				default: begin
					nc = $urandom_range(1500);
					ne = nc + $urandom_range(600);
					pe = ne + $urandom_range(1500);
					pc = pe + $urandom_range(SAMPLE_MAX - pe);
				end
			endcase
			// Sender light and receiver heavy, then swapped, then no idling.
			if (b < 2) begin
				gap_pct   = 21;
				stall_pct = 78;
			end else if (b < 4) begin
				gap_pct   = 78;
				stall_pct = 21;
			end else begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			program_thresholds(SAMPLE_BITS'(ne), SAMPLE_BITS'(nc), SAMPLE_BITS'(pe),
				SAMPLE_BITS'(pc));
			for (int i = 0; i < BLOCK_PAIRS; i++)
				send_pair(pick_sample(phase_x), pick_sample(phase_y));
		end
	endtask

	// Receiver side: random stall per the current mix.
	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Compare each result beat with the oldest expectation, field by field.
	always @(posedge clk) begin : check_results
		jdd_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result with nothing expected, event_x", out_data.event_x, 0);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (out_data.event_x !== want.event_x)
					flag_mismatch("event_x", out_data.event_x, want.event_x);
				if (out_data.event_y !== want.event_y)
					flag_mismatch("event_y", out_data.event_y, want.event_y);
				if (out_data.held_x !== want.held_x)
					flag_mismatch("held_x", out_data.held_x, want.held_x);
				if (out_data.held_y !== want.held_y)
					flag_mismatch("held_y", out_data.held_y, want.held_y);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_NEG_ENTER;
		cfg_data  = '0;
		gap_pct   = 21;
		stall_pct = 78;
		error_count     = 0;
		cycle_count     = 0;
		pairs_sent      = 0;
		results_checked = 0;
		press_count     = 0;
		release_count   = 0;
		settings_used   = 1;
		thr.neg_enter   = NEG_ENTER_RST;
		thr.neg_confirm = NEG_CONFIRM_RST;
		thr.pos_enter   = POS_ENTER_RST;
		thr.pos_confirm = POS_CONFIRM_RST;
		phase_x = PH_IDLE;
		phase_y = PH_IDLE;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_gestures();
		test_threshold_extremes();
		test_random_gestures();
		settle();

		$display("Sent %0d sample pairs over %0d threshold settings; %0d results checked.",
			pairs_sent, settings_used, results_checked);
		$display("Expected events seen: %0d presses and %0d releases; %0d mismatches.",
			press_count, release_count, error_count);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
